// ===== sv/lfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_pkg : shared types and constants of the LRU frame replacer
// Frame count, field widths, command codes, sequencer states and the
// broadcast operation word driven into the cell chain.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int NumFrames = 64;
  localparam int FrameW    = 6;
  localparam int CntW      = 7;

  typedef enum logic [1:0] {
    CmdVictim = 2'd0,
    CmdPin    = 2'd1,
    CmdUnpin  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StMatch = 2'd1,
    StApply = 2'd2
  } state_e;

  // operation broadcast to every cell during the apply cycle
  typedef struct packed {
    logic              remove;
    logic              append;
    logic              victim;
    logic [FrameW-1:0] key;
  } lfr_op_t;

endpackage

`default_nettype wire

// ===== sv/lfr_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_cell : one slot of the age-ordered frame chain
// Holds one frame number and its valid flag; on a removal at or before this
// slot it takes its newer neighbour's contents, on an append it fills itself
// if it is the first empty slot.
// ----------------------------------------------------------------------------
module lfr_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  lfr_pkg::lfr_op_t           op_i,
  input  wire                        hit_i,
  input  wire                        prev_valid_i,
  input  wire  [lfr_pkg::FrameW-1:0] next_frame_i,
  input  wire                        next_valid_i,
  output logic [lfr_pkg::FrameW-1:0] frame_o,
  output logic                       valid_o,
  output logic                       hit_o
);
  import lfr_pkg::*;

  logic [FrameW-1:0] frame_q, frame_d;
  logic              valid_q, valid_d;
  logic              match;

  assign match = valid_q & (op_i.victim | (frame_q == op_i.key));
  assign hit_o = hit_i | match;

  always_comb begin
    frame_d = frame_q;
    valid_d = valid_q;
    if (op_i.remove && hit_o) begin
      // close the gap: take the newer neighbour
      frame_d = next_frame_i;
      valid_d = next_valid_i;
    end else if (op_i.append && !valid_q && prev_valid_i) begin
      frame_d = op_i.key;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign frame_o = frame_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== sv/lfr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_ctrl : command sequencer of the LRU frame replacer
// Captures a command, decides in the match cycle what it does, drives the
// cell chain in the apply cycle and registers the result item.
// ----------------------------------------------------------------------------
module lfr_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  input  wire  [1:0]                 command_i,
  input  wire  [lfr_pkg::FrameW-1:0] frame_i,
  input  wire  [lfr_pkg::FrameW-1:0] oldest_frame_i,
  output logic                       busy,
  output lfr_pkg::lfr_op_t           op_o,
  output logic                       done_o,
  output logic                       found_o,
  output logic [lfr_pkg::FrameW-1:0] victim_frame_o,
  output logic [lfr_pkg::CntW-1:0]   evictable_count_o
);
  import lfr_pkg::*;

  state_e              state_q, state_d;
  logic [1:0]          cmd_q;
  logic [FrameW-1:0]   key_q;
  logic                rm_q, rm_d;
  logic                ap_q, ap_d;
  logic                found_q, found_d;
  logic [FrameW-1:0]   vict_q, vict_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [NumFrames-1:0] present_q, present_d;
  logic [FrameW-1:0]   target;
  logic                in_range;
  logic                accept;
  logic                done_q;
  logic                res_found_q;
  logic [FrameW-1:0]   res_vict_q;
  logic [CntW-1:0]     res_count_q;

  assign accept   = start && (state_q == StIdle);
  assign in_range = ({1'b0, key_q} < CntW'(NumFrames));
  assign target   = (cmd_q == CmdVictim) ? vict_q : key_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start) state_d = StMatch;
      StMatch: state_d = StApply;
      StApply: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy        = (state_q != StIdle);
    op_o.remove = (state_q == StApply) && rm_q;
    op_o.append = (state_q == StApply) && ap_q;
    op_o.victim = (cmd_q == CmdVictim);
    op_o.key    = key_q;
  end

  // decision in the match cycle
  always_comb begin
    rm_d    = 1'b0;
    ap_d    = 1'b0;
    found_d = 1'b0;
    unique case (cmd_q)
      CmdVictim: begin
        rm_d    = (count_q != '0);
        found_d = (count_q != '0);
      end
      CmdPin:   rm_d = in_range && present_q[key_q];
      CmdUnpin: ap_d = in_range && !present_q[key_q];
      default: begin
        rm_d = 1'b0;
      end
    endcase
    vict_d = found_d ? oldest_frame_i : '0;
  end

  // presence map and count in the apply cycle
  always_comb begin
    present_d = present_q;
    count_d   = count_q;
    if (state_q == StApply) begin
      if (rm_q) begin
        present_d[target] = 1'b0;
        count_d           = count_q - CntW'(1);
      end else if (ap_q) begin
        present_d[target] = 1'b1;
        count_d           = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rm_q      <= 1'b0;
      ap_q      <= 1'b0;
      count_q   <= '0;
      present_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      present_q <= present_d;
      done_q    <= (state_q == StApply);
      if (state_q == StMatch) begin
        rm_q <= rm_d;
        ap_q <= ap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= frame_i;
    end
    if (state_q == StMatch) begin
      found_q <= found_d;
      vict_q  <= vict_d;
    end
    if (state_q == StApply) begin
      res_found_q <= found_q;
      res_vict_q  <= vict_q;
      res_count_q <= count_d;
    end
  end

  assign done_o            = done_q;
  assign found_o           = res_found_q;
  assign victim_frame_o    = res_vict_q;
  assign evictable_count_o = res_count_q;

endmodule

`default_nettype wire

// ===== sv/lru_frame_replacer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_frame_replacer_top : LRU replacer over a chain of frame slots
// Sequencing: a command is captured while idle, decided in the match state and
//   applied to the slot chain in the apply state; done_o then rises with its
//   result item. busy stays high meanwhile, so a new command is taken only
//   after the last one has been applied.
// Reset: all slots empty, presence map clear, count zero; done_o is low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module lru_frame_replacer_top (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  wire  [1:0]                 command_i,
  input  wire  [lfr_pkg::FrameW-1:0] frame_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [lfr_pkg::FrameW-1:0] victim_frame_o,
  output logic [lfr_pkg::CntW-1:0]   evictable_count_o
);
  import lfr_pkg::*;

  // Slot 0 is the oldest frame; valid slots are always packed from slot 0.
  lfr_op_t           op;
  logic [FrameW-1:0] slot_frame [NumFrames];
  logic              slot_valid [NumFrames];
  logic              slot_hit   [NumFrames];

  lfr_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .command_i         (command_i),
    .frame_i           (frame_i),
    .oldest_frame_i    (slot_frame[0]),
    .busy              (busy),
    .op_o              (op),
    .done_o            (done_o),
    .found_o           (found_o),
    .victim_frame_o    (victim_frame_o),
    .evictable_count_o (evictable_count_o)
  );

  // Build the chain: a hit ripples towards the newer end, data moves back
  // one slot wherever a removal lies at or before it.
  for (genvar i = 0; i < NumFrames; i++) begin : g_slot
    logic              hit_in;
    logic              prev_valid;
    logic [FrameW-1:0] next_frame;
    logic              next_valid;

    if (i == 0) begin : g_head
      assign hit_in     = 1'b0;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign hit_in     = slot_hit[i-1];
      assign prev_valid = slot_valid[i-1];
    end

    if (i == NumFrames-1) begin : g_tail
      assign next_frame = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_frame = slot_frame[i+1];
      assign next_valid = slot_valid[i+1];
    end

    lfr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .hit_i        (hit_in),
      .prev_valid_i (prev_valid),
      .next_frame_i (next_frame),
      .next_valid_i (next_valid),
      .frame_o      (slot_frame[i]),
      .valid_o      (slot_valid[i]),
      .hit_o        (slot_hit[i])
    );
  end

endmodule

`default_nettype wire

// ===== tb/tb_lru_frame_replacer_top.sv =====
// ----------------------------------------------------------------------------
// tb_lru_frame_replacer_top : self-checking bench for the LRU frame replacer
// Drives victim, pin, unpin and unused commands through the start/busy
// handshake. Every accepted item is run through a queue-based LRU predictor,
// and each done_o strobe is checked field by field against the oldest
// expectation. A short table of directed items comes first, then a shuffled
// fill of all 64 frames and a drain, then random phases that mix the
// commands with shifting bias.
// ----------------------------------------------------------------------------
module tb_lru_frame_replacer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;

  // Command code that the block must treat as a no-op
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int NumDirected = 23;
  localparam int NumPhases   = 9;
  localparam int PhaseItems  = 80;
  localparam int CycleLimit  = 200_000;
  localparam int MaxReports  = 10;

  typedef struct packed {
    logic              found;
    logic [FrameW-1:0] victim;
    logic [CntW-1:0]   evict_cnt;
  } replacer_result_t;

  // One directed item; want is used only where typed is set
  typedef struct packed {
    logic [1:0]       cmd;
    logic [FrameW-1:0] frame;
    bit               typed;
    replacer_result_t want;
  } directed_row_t;

  // Clock, reset and block inputs, all known from time zero
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              start     = 1'b0;
  logic [1:0]        command_i = 2'd0;
  logic [FrameW-1:0] frame_i   = '0;

  logic              busy;
  logic              done_o;
  logic              found_o;
  logic [FrameW-1:0] victim_frame_o;
  logic [CntW-1:0]   evictable_count_o;

  lru_frame_replacer_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .frame_i          (frame_i),
    .done_o           (done_o),
    .found_o          (found_o),
    .victim_frame_o   (victim_frame_o),
    .evictable_count_o(evictable_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: evictable frames oldest first, plus the presence map
  logic [FrameW-1:0] lru_order[$];
  bit                resident[NumFrames];

  // Results still owed by the block, oldest first
  replacer_result_t  pending_results[$];

  directed_row_t     dir_rows[NumDirected];

  bit idle_en     = 1'b1;
  int mismatches  = 0;
  int items_sent  = 0;
  int evictions   = 0;
  int peak_count  = 0;
  int cycle_count = 0;

  // Apply one command to the predictor and return the result it must give
  function automatic replacer_result_t lru_apply(input logic [1:0] cmd,
                                                 input logic [FrameW-1:0] frm);
    replacer_result_t r;
    int pos;
    r   = '0;
    pos = 0;
    case (cmd)
      CmdVictim: begin
        if (lru_order.size() > 0) begin
          r.found  = 1'b1;
          r.victim = lru_order.pop_front();
          resident[r.victim] = 1'b0;
        end
      end
      CmdPin: begin
        // drop the frame wherever it sits in the order
        if (resident[frm]) begin
          foreach (lru_order[i]) if (lru_order[i] == frm) pos = i;
          lru_order.delete(pos);
          resident[frm] = 1'b0;
        end
      end
      CmdUnpin: begin
        // a frame already present keeps its place
        if (!resident[frm]) begin
          lru_order.push_back(frm);
          resident[frm] = 1'b1;
        end
      end
      default: ;
    endcase
    r.evict_cnt = CntW'(lru_order.size());
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  // Present one item, hold it until the block takes it, then log the
  // expectation. An optional gap before the item lowers start for a while;
  // otherwise start simply stays high from the previous item.
  task automatic issue_item(input logic [1:0] cmd, input logic [FrameW-1:0] frm,
                            input bit typed, input replacer_result_t typed_want);
    replacer_result_t want;
    int gap;
    gap = 0;
    if (idle_en) repeat (4) if ($urandom_range(99) < 24) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    command_i <= cmd;
    frame_i   <= frm;
    @(posedge clk_i);
    // busy read here is its value before this edge
    while (busy) @(posedge clk_i);
    want = lru_apply(cmd, frm);
    if (typed) want = typed_want;
    pending_results.push_back(want);
    items_sent++;
    if (want.found) evictions++;
    if (int'(want.evict_cnt) > peak_count) peak_count = want.evict_cnt;
  endtask

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin : result_check
    replacer_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result (count)", -1, evictable_count_o);
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found)
          flag_mismatch("found", want.found, found_o);
        if (victim_frame_o !== want.victim)
          flag_mismatch("victim_frame", want.victim, victim_frame_o);
        if (evictable_count_o !== want.evict_cnt)
          flag_mismatch("evictable_count", want.evict_cnt, evictable_count_o);
      end
    end
  end

  // Watchdog: end the run if the handshake ever hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FrameW-1:0] deck[NumFrames];
    logic [FrameW-1:0] tmp;
    logic [FrameW-1:0] frm;
    logic [1:0]        cmd;
    int                j;
    int                kind;
    int                roll;
    int                vict_lim;
    int                pin_lim;

    // Directed items: empty-list corners first, then removal from the
    // oldest, middle and newest positions, and the unused command
    dir_rows = '{
      '{CmdVictim, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},  // victim while empty
      '{CmdPin,    6'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},  // pin an absent frame
      '{CmdUnused, 6'd63, 1'b1, '{1'b0, 6'd0, 7'd0}},  // unused command
      '{CmdUnpin,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd1}},
      '{CmdUnpin,  6'd63, 1'b1, '{1'b0, 6'd0, 7'd2}},
      '{CmdUnpin,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd2}},  // already present, stays put
      '{CmdUnpin,  6'd42, 1'b0, '0},
      '{CmdVictim, 6'd0,  1'b1, '{1'b1, 6'd0, 7'd2}},  // oldest is frame 0
      '{CmdPin,    6'd63, 1'b0, '0},
      '{CmdPin,    6'd63, 1'b0, '0},
      '{CmdUnused, 6'd21, 1'b0, '0},
      '{CmdVictim, 6'd63, 1'b0, '0},                    // frame field ignored
      '{CmdVictim, 6'd0,  1'b0, '0},
      '{CmdUnpin,  6'd21, 1'b0, '0},
      '{CmdUnpin,  6'd42, 1'b0, '0},
      '{CmdUnpin,  6'd63, 1'b0, '0},
      '{CmdPin,    6'd42, 1'b0, '0},                    // unlink from the middle
      '{CmdUnpin,  6'd42, 1'b0, '0},
      '{CmdPin,    6'd42, 1'b0, '0},                    // unlink the newest
      '{CmdPin,    6'd21, 1'b0, '0},                    // unlink the oldest
      '{CmdVictim, 6'd0,  1'b0, '0},
      '{CmdVictim, 6'd0,  1'b0, '0},
      '{CmdUnused, 6'd0,  1'b0, '0}
    };

    // Hold reset, then release it on an edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++)
      issue_item(dir_rows[i].cmd, dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want);

    // Fill every frame in shuffled order with no idling, so the count
    // reaches its top, then knock on eight present frames and drain
    idle_en = 1'b0;
    for (int i = 0; i < NumFrames; i++) deck[i] = FrameW'(i);
    for (int i = NumFrames - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = deck[i];
      deck[i] = deck[j];
      deck[j] = tmp;
    end
    foreach (deck[i]) issue_item(CmdUnpin, deck[i], 1'b0, '0);
    idle_en = 1'b1;
    repeat (8) issue_item(CmdUnpin, FrameW'($urandom_range(NumFrames - 1)), 1'b0, '0);
    while (lru_order.size() > 0)
      issue_item(CmdVictim, FrameW'($urandom_range(NumFrames - 1)), 1'b0, '0);
    issue_item(CmdVictim, FrameW'($urandom_range(NumFrames - 1)), 1'b0, '0);

    // Random phases: each leans towards growing, holding or shrinking the
    // list. Pins mostly aim at frames that are present so that unlinks
    // land all over the order. Two middle phases run with no idling.
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_en = !(ph == 3 || ph == 4);
      kind    = $urandom_range(2);
      case (kind)
        0:       begin vict_lim = 22; pin_lim = 40; end
        1:       begin vict_lim = 36; pin_lim = 62; end
        default: begin vict_lim = 50; pin_lim = 85; end
      endcase
      repeat (PhaseItems) begin
        roll = $urandom_range(99);
        if (roll < 4)             cmd = CmdUnused;
        else if (roll < vict_lim) cmd = CmdVictim;
        else if (roll < pin_lim)  cmd = CmdPin;
        else                      cmd = CmdUnpin;
        frm = FrameW'($urandom_range(NumFrames - 1));
        if (cmd == CmdPin && lru_order.size() > 0 && $urandom_range(99) < 70)
          frm = lru_order[$urandom_range(lru_order.size() - 1)];
        issue_item(cmd, frm, 1'b0, '0);
      end
    end

    // Drain: let every owed result arrive, then run on idle before the report
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d commands (%0d evictions), evictable count peaked at %0d.",
             items_sent, evictions, peak_count);
    $display("Mismatches: %0d, results left outstanding: %0d.",
             mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lfr_pkg.sv
sv/lfr_cell.sv
sv/lfr_ctrl.sv
sv/lru_frame_replacer_top.sv
tb/tb_lru_frame_replacer_top.sv
